@@ src/heap_allocation_tracker_assert.svh @@
// Assertion macros for the heap allocation tracker.
`ifndef HEAP_ALLOCATION_TRACKER_ASSERT_SVH
`define HEAP_ALLOCATION_TRACKER_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define HAT_ASSERT_IMPL(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("heap tracker check failed");
`define HAT_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("heap tracker check failed");
`else
`define HAT_ASSERT_IMPL(label, clk, rst_n, a, b)
`define HAT_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif

`endif

@@ src/hat_pkg.sv @@
// Shared types and constants of the heap allocation tracker.
package hat_pkg;

    localparam int LIVE_DEPTH  = 16;
    localparam int FREED_DEPTH = 16;
    localparam int LIVE_IDX_W  = $clog2(LIVE_DEPTH);
    localparam int LIVE_CNT_W  = $clog2(LIVE_DEPTH + 1);
    localparam int FREED_IDX_W = $clog2(FREED_DEPTH);
    localparam int FREED_CNT_W = $clog2(FREED_DEPTH + 1);
    localparam int Q_DEPTH     = 2;
    localparam int Q_PTR_W     = $clog2(Q_DEPTH);
    localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_DOUBLE   = 3'd1;
    localparam logic [2:0] ST_INVALID  = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_RUNKNOWN = 3'd4;
    localparam logic [2:0] ST_LEAK     = 3'd5;
    localparam logic [2:0] ST_DONE     = 3'd6;

    localparam logic [1:0] ACT_ALLOC   = 2'd0;
    localparam logic [1:0] ACT_FREE    = 2'd1;
    localparam logic [1:0] ACT_REALLOC = 2'd2;

    typedef enum logic [1:0] {
        OP_ALLOC,
        OP_FREE,
        OP_MOVE,
        OP_SCAN
    } op_t;

    typedef struct packed {
        op_t         op;
        logic        widen;
        logic [31:0] addr;
        logic [31:0] size;
        logic [31:0] key;
    } cmd_t;

endpackage

@@ src/hat_front.sv @@
// Front end: accepts events, classifies them and queues commands for the back end.
module hat_front (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    output logic         busy,
    input  logic [1:0]   action,
    input  logic [31:0]  block_addr,
    input  logic [31:0]  block_size,
    input  logic [31:0]  prior_addr,
    output logic         cmd_valid,
    output hat_pkg::cmd_t cmd,
    input  logic         cmd_pop
);
    import hat_pkg::*;

    cmd_t               q_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wp_reg;
    logic [Q_PTR_W-1:0] rp_reg;
    logic [Q_CNT_W-1:0] cnt_reg;
    cmd_t               cls;
    logic               push;
    logic               pop;

    always_comb
    begin
        cls.addr  = block_addr;
        cls.size  = block_size;
        cls.key   = block_addr;
        cls.widen = 1'b0;
        cls.op    = OP_SCAN;
        case (action)
            ACT_ALLOC:
            begin
                cls.op    = OP_ALLOC;
                cls.widen = 1'b1;
            end
            ACT_FREE:
            begin
                cls.op = OP_FREE;
            end
            ACT_REALLOC:
            begin
                cls.widen = 1'b1;
                cls.key   = prior_addr;
                if (prior_addr == 32'd0)
                    cls.op = OP_ALLOC;
                else if (block_size == 32'd0)
                    cls.op = OP_FREE;
                else
                    cls.op = OP_MOVE;
            end
            default:
            begin
                cls.op = OP_SCAN;
            end
        endcase
    end

    assign busy      = (cnt_reg == Q_CNT_W'(Q_DEPTH));
    assign cmd_valid = (cnt_reg != '0);
    assign push      = start && !busy;
    assign pop       = cmd_pop && cmd_valid;
    assign cmd       = q_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wp_reg] <= cls;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= (wp_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            if (pop)
                rp_reg <= (rp_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rp_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

@@ src/hat_back.sv @@
// Back end: live table, freed ring, heap bounds and result generation.
module hat_back (
    input  logic         clk,
    input  logic         rst_n,
    input  logic [7:0]   redzone,
    input  logic         cmd_valid,
    input  hat_pkg::cmd_t cmd,
    output logic         cmd_pop,
    output logic         strobe,
    output logic [2:0]   status,
    output logic [31:0]  report_addr,
    output logic [31:0]  report_len,
    output logic [31:0]  heap_low,
    output logic [31:0]  heap_high,
    output logic         last
);
    import hat_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_APPLY,
        S_SCAN
    } state_t;

    state_t                 state_reg;
    cmd_t                   cmd_reg;
    logic [31:0]            lo_reg;
    logic [31:0]            hi_reg;
    logic                   found_reg;
    logic [LIVE_IDX_W-1:0]  idx_reg;
    logic                   fhit_reg;
    logic [LIVE_CNT_W-1:0]  live_count_reg;
    logic [FREED_CNT_W-1:0] freed_count_reg;
    logic [FREED_IDX_W-1:0] freed_head_reg;
    logic [31:0]            bound_low_reg;
    logic [31:0]            bound_high_reg;
    logic [LIVE_CNT_W-1:0]  scan_idx_reg;
    logic                   strobe_reg;
    logic [2:0]             status_reg;
    logic [31:0]            raddr_reg;
    logic [31:0]            rlen_reg;
    logic                   last_reg;

    logic [31:0] live_start [LIVE_DEPTH];
    logic [31:0] live_end   [LIVE_DEPTH];
    logic [31:0] freed_key  [FREED_DEPTH];

    logic [31:0]           fp_t;
    logic [31:0]           fp_len;
    logic [31:0]           fp_lo;
    logic [31:0]           fp_hi;
    logic                  m_found;
    logic [LIVE_IDX_W-1:0] m_idx;
    logic                  m_fhit;
    logic                  full;
    logic                  do_remove;
    logic                  do_alloc;
    logic                  do_move;
    logic [31:0]           low_next;
    logic [31:0]           high_next;
    logic [31:0]           scan_start;
    logic [31:0]           scan_end;

    // footprint of the block in cmd_reg
    always_comb
    begin
        fp_t   = cmd_reg.size + {23'd0, redzone, 1'b0} + 32'd4;
        fp_len = (fp_t < 32'd16) ? 32'd16 : ((fp_t + 32'd7) & ~32'd7);
        fp_lo  = cmd_reg.addr - {24'd0, redzone} - 32'd4;
        fp_hi  = cmd_reg.addr - {24'd0, redzone} + fp_len;
    end

    // first live match and freed ring membership
    always_comb
    begin
        m_found = 1'b0;
        m_idx   = '0;
        m_fhit  = 1'b0;
        for (int i = LIVE_DEPTH - 1; i >= 0; i--)
        begin
            if ((LIVE_CNT_W'(i) < live_count_reg) && (live_start[i] == cmd_reg.key))
            begin
                m_found = 1'b1;
                m_idx   = LIVE_IDX_W'(i);
            end
        end
        for (int j = 0; j < FREED_DEPTH; j++)
        begin
            if ((FREED_CNT_W'(j) < freed_count_reg) && (freed_key[j] == cmd_reg.key))
                m_fhit = 1'b1;
        end
    end

    assign full      = (live_count_reg == LIVE_CNT_W'(LIVE_DEPTH));
    assign do_remove = (state_reg == S_APPLY) && found_reg &&
                       ((cmd_reg.op == OP_FREE) || (cmd_reg.op == OP_MOVE));
    assign do_move   = do_remove && (cmd_reg.op == OP_MOVE);
    assign do_alloc  = (state_reg == S_APPLY) && (cmd_reg.op == OP_ALLOC) && !full;
    assign low_next  = (cmd_reg.widen && (lo_reg < bound_low_reg)) ? lo_reg : bound_low_reg;
    assign high_next = (cmd_reg.widen && (bound_high_reg < hi_reg)) ? hi_reg : bound_high_reg;
    assign scan_start = live_start[scan_idx_reg[LIVE_IDX_W-1:0]];
    assign scan_end   = live_end[scan_idx_reg[LIVE_IDX_W-1:0]];
    assign cmd_pop    = (state_reg == S_IDLE) && cmd_valid;

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && cmd_valid)
            cmd_reg <= cmd;
        if (state_reg == S_CALC)
        begin
            lo_reg    <= fp_lo;
            hi_reg    <= fp_hi;
            found_reg <= m_found;
            idx_reg   <= m_idx;
            fhit_reg  <= m_fhit;
        end
        // removal closes the gap; a move then lands at the tail
        if (do_remove)
        begin
            for (int i = 0; i < LIVE_DEPTH - 1; i++)
            begin
                if (LIVE_IDX_W'(i) >= idx_reg)
                begin
                    live_start[i] <= live_start[i + 1];
                    live_end[i]   <= live_end[i + 1];
                end
            end
            freed_key[freed_head_reg] <= cmd_reg.key;
        end
        if (do_move)
        begin
            live_start[LIVE_IDX_W'(live_count_reg - 1'b1)] <= cmd_reg.addr;
            live_end[LIVE_IDX_W'(live_count_reg - 1'b1)]   <= cmd_reg.addr + cmd_reg.size;
        end
        if (do_alloc)
        begin
            live_start[live_count_reg[LIVE_IDX_W-1:0]] <= cmd_reg.addr;
            live_end[live_count_reg[LIVE_IDX_W-1:0]]   <= cmd_reg.addr + cmd_reg.size;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            live_count_reg  <= '0;
            freed_count_reg <= '0;
            freed_head_reg  <= '0;
            bound_low_reg   <= 32'hffffffff;
            bound_high_reg  <= 32'd0;
            scan_idx_reg    <= '0;
            strobe_reg      <= 1'b0;
            status_reg      <= ST_OK;
            raddr_reg       <= 32'd0;
            rlen_reg        <= 32'd0;
            last_reg        <= 1'b0;
        end
        else
        begin
            strobe_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                        state_reg <= (cmd.op == OP_SCAN) ? S_SCAN : S_CALC;
                    scan_idx_reg <= '0;
                end
                S_CALC:
                begin
                    state_reg <= S_APPLY;
                end
                S_APPLY:
                begin
                    state_reg      <= S_IDLE;
                    bound_low_reg  <= low_next;
                    bound_high_reg <= high_next;
                    strobe_reg     <= 1'b1;
                    last_reg       <= 1'b1;
                    rlen_reg       <= 32'd0;
                    status_reg     <= ST_OK;
                    raddr_reg      <= 32'd0;
                    case (cmd_reg.op)
                        OP_ALLOC:
                        begin
                            if (full)
                            begin
                                status_reg <= ST_FULL;
                                raddr_reg  <= cmd_reg.addr;
                            end
                            else
                                live_count_reg <= live_count_reg + 1'b1;
                        end
                        OP_FREE:
                        begin
                            if (!found_reg)
                            begin
                                status_reg <= fhit_reg ? ST_DOUBLE : ST_INVALID;
                                raddr_reg  <= cmd_reg.key;
                            end
                            else
                                live_count_reg <= live_count_reg - 1'b1;
                        end
                        OP_MOVE:
                        begin
                            if (!found_reg)
                            begin
                                status_reg <= ST_RUNKNOWN;
                                raddr_reg  <= cmd_reg.key;
                            end
                        end
                        default:
                        begin
                            status_reg <= ST_OK;
                        end
                    endcase
                    if (do_remove)
                    begin
                        freed_head_reg <= (freed_head_reg == FREED_IDX_W'(FREED_DEPTH - 1)) ?
                                          '0 : freed_head_reg + 1'b1;
                        if (freed_count_reg != FREED_CNT_W'(FREED_DEPTH))
                            freed_count_reg <= freed_count_reg + 1'b1;
                    end
                end
                S_SCAN:
                begin
                    strobe_reg <= 1'b1;
                    if (scan_idx_reg < live_count_reg)
                    begin
                        status_reg   <= ST_LEAK;
                        raddr_reg    <= scan_start;
                        rlen_reg     <= scan_end - scan_start;
                        last_reg     <= 1'b0;
                        scan_idx_reg <= scan_idx_reg + 1'b1;
                    end
                    else
                    begin
                        status_reg <= ST_DONE;
                        raddr_reg  <= 32'd0;
                        rlen_reg   <= 32'd0;
                        last_reg   <= 1'b1;
                        state_reg  <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign strobe      = strobe_reg;
    assign status      = status_reg;
    assign report_addr = raddr_reg;
    assign report_len  = rlen_reg;
    assign heap_low    = bound_low_reg;
    assign heap_high   = bound_high_reg;
    assign last        = last_reg;

endmodule

@@ src/heap_allocation_tracker.sv @@
// Heap allocation tracker top level: redzone register, front end and back end.
// An event is taken when start is high and busy is low; up to two events wait in
// a command queue, and busy rises only when that queue is full. Allocate, free and
// reallocate pass through the back-end steps in order (pop, match and footprint, update) and
// give one result strobe; a leak scan of N live blocks gives N leak strobes and then
// a done strobe, at one result a cycle. Results appear for
// one cycle and cannot be held off by the receiver. Redzone writes take effect at
// once and must be made while no event is in flight.
module heap_allocation_tracker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  action,
    input  logic [31:0] block_addr,
    input  logic [31:0] block_size,
    input  logic [31:0] prior_addr,
    input  logic        redzone_we,
    input  logic [7:0]  redzone_data,
    output logic        strobe,
    output logic [2:0]  status,
    output logic [31:0] report_addr,
    output logic [31:0] report_len,
    output logic [31:0] heap_low,
    output logic [31:0] heap_high,
    output logic        last
);
    import hat_pkg::*;

    `include "heap_allocation_tracker_assert.svh"

    logic [7:0] redzone_reg;
    logic       cmd_valid;
    cmd_t       cmd;
    logic       cmd_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            redzone_reg <= 8'd16;
        else if (redzone_we)
            redzone_reg <= redzone_data;
    end

    hat_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .action     (action),
        .block_addr (block_addr),
        .block_size (block_size),
        .prior_addr (prior_addr),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_pop    (cmd_pop)
    );

    hat_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .redzone     (redzone_reg),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .cmd_pop     (cmd_pop),
        .strobe      (strobe),
        .status      (status),
        .report_addr (report_addr),
        .report_len  (report_len),
        .heap_low    (heap_low),
        .heap_high   (heap_high),
        .last        (last)
    );

    `HAT_ASSERT_IMPL(a_notlast_is_leak, clk, rst_n, strobe && !last, status == ST_LEAK)
    `HAT_ASSERT_IMPL(a_done_is_last, clk, rst_n, strobe && (status == ST_DONE), last)
    `HAT_ASSERT_IMPL(a_ok_no_addr, clk, rst_n, strobe && ((status == ST_OK) || (status == ST_DONE)), report_addr == 32'd0)
    `HAT_ASSERT_NEXT(a_leak_then_more, clk, rst_n, strobe && !last, strobe)

endmodule

@@ test/heap_allocation_tracker_tb.sv @@
// Self-checking testbench for the heap allocation tracker: directed table, then random events.
`timescale 1ns / 1ps

module heap_allocation_tracker_tb;
    import hat_pkg::*;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] report_addr;
        logic [31:0] report_len;
        logic [31:0] heap_low;
        logic [31:0] heap_high;
        logic        last;
    } report_t;

    typedef struct {
        logic [1:0]  action;
        logic [31:0] addr;
        logic [31:0] size;
        logic [31:0] prior;
        bit          typed;
        report_t     want;
    } vec_t;

    localparam logic [1:0] ACT_SCAN = 2'd3;
    localparam int RANDOM_EVENTS = 435;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  action;
    logic [31:0] block_addr;
    logic [31:0] block_size;
    logic [31:0] prior_addr;
    logic        redzone_we;
    logic [7:0]  redzone_data;
    logic        strobe;
    logic [2:0]  status;
    logic [31:0] report_addr;
    logic [31:0] report_len;
    logic [31:0] heap_low;
    logic [31:0] heap_high;
    logic        last;

    heap_allocation_tracker dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .action(action), .block_addr(block_addr), .block_size(block_size),
        .prior_addr(prior_addr), .redzone_we(redzone_we), .redzone_data(redzone_data),
        .strobe(strobe), .status(status), .report_addr(report_addr),
        .report_len(report_len), .heap_low(heap_low), .heap_high(heap_high),
        .last(last)
    );

    // shadow of the tracker
    logic [31:0] m_redzone;
    logic [31:0] m_start [LIVE_DEPTH];
    logic [31:0] m_end [LIVE_DEPTH];
    int          m_live;
    logic [31:0] m_freed [FREED_DEPTH];
    int          m_freed_cnt;
    int          m_freed_head;
    logic [31:0] m_low;
    logic [31:0] m_high;

    report_t     pending_reports [$];
    int          errors;
    int          mismatches;
    int          results_seen;
    int          scans_seen;
    int          sender_idle;
    int          leaks_seen;

    initial begin
        clk = 1'b0;
        forever
        begin
            #4 clk = 1'b1;
            #4 clk = 1'b0;
        end
    end

    initial begin
        #50ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic void track_reset();
        m_redzone = 32'd16;
        m_live = 0;
        m_freed_cnt = 0;
        m_freed_head = 0;
        m_low = 32'hffffffff;
        m_high = 32'd0;
    endfunction

    function automatic void widen_bounds(logic [31:0] a, logic [31:0] s);
        logic [31:0] t;
        logic [31:0] len;
        logic [31:0] lo;
        logic [31:0] hi;
        t = s + 2 * m_redzone + 32'd4;
        len = (t < 32'd16) ? 32'd16 : ((t + 32'd7) & ~32'd7);
        lo = a - m_redzone - 32'd4;
        hi = a - m_redzone + len;
        if (lo < m_low) m_low = lo;
        if (m_high < hi) m_high = hi;
    endfunction

    function automatic int live_index(logic [31:0] key);
        for (int i = 0; i < m_live; i++)
            if (m_start[i] == key) return i;
        return -1;
    endfunction

    function automatic bit was_freed(logic [31:0] key);
        for (int i = 0; i < m_freed_cnt; i++)
            if (m_freed[i] == key) return 1'b1;
        return 1'b0;
    endfunction

    function automatic void retire_block(int idx);
        m_freed[m_freed_head] = m_start[idx];
        m_freed_head = (m_freed_head + 1) % FREED_DEPTH;
        if (m_freed_cnt < FREED_DEPTH) m_freed_cnt++;
        for (int i = idx; i + 1 < m_live; i++)
        begin
            m_start[i] = m_start[i + 1];
            m_end[i] = m_end[i + 1];
        end
        m_live--;
    endfunction

    function automatic logic [2:0] add_block(logic [31:0] a, logic [31:0] s);
        if (m_live >= LIVE_DEPTH) return ST_FULL;
        m_start[m_live] = a;
        m_end[m_live] = a + s;
        m_live++;
        return ST_OK;
    endfunction

    function automatic logic [2:0] free_block(logic [31:0] a);
        int idx;
        idx = live_index(a);
        if (idx < 0) return was_freed(a) ? ST_DOUBLE : ST_INVALID;
        retire_block(idx);
        return ST_OK;
    endfunction

    function automatic report_t make_report(logic [2:0] st, logic [31:0] ra,
                                            logic [31:0] rl, logic lst);
        report_t r;
        r.status = st;
        r.report_addr = ra;
        r.report_len = rl;
        r.heap_low = m_low;
        r.heap_high = m_high;
        r.last = lst;
        return r;
    endfunction

    // computes the reports one event produces and queues them
    function automatic void predict_event(logic [1:0] act, logic [31:0] a,
                                          logic [31:0] s, logic [31:0] p);
        logic [2:0] st;
        int idx;
        case (act)
            ACT_ALLOC:
            begin
                widen_bounds(a, s);
                st = add_block(a, s);
                pending_reports.push_back(make_report(st, st == ST_OK ? 32'd0 : a,
                                                      32'd0, 1'b1));
            end
            ACT_FREE:
            begin
                st = free_block(a);
                pending_reports.push_back(make_report(st, st == ST_OK ? 32'd0 : a,
                                                      32'd0, 1'b1));
            end
            ACT_REALLOC:
            begin
                widen_bounds(a, s);
                if (p == 32'd0)
                begin
                    st = add_block(a, s);
                    pending_reports.push_back(make_report(st, st == ST_OK ? 32'd0 : a,
                                                          32'd0, 1'b1));
                end
                else if (s == 32'd0)
                begin
                    st = free_block(p);
                    pending_reports.push_back(make_report(st, st == ST_OK ? 32'd0 : p,
                                                          32'd0, 1'b1));
                end
                else
                begin
                    idx = live_index(p);
                    if (idx < 0)
                        pending_reports.push_back(make_report(ST_RUNKNOWN, p, 32'd0, 1'b1));
                    else
                    begin
                        retire_block(idx);
                        void'(add_block(a, s));
                        pending_reports.push_back(make_report(ST_OK, 32'd0, 32'd0, 1'b1));
                    end
                end
            end
            default:
            begin
                for (int i = 0; i < m_live; i++)
                    pending_reports.push_back(make_report(ST_LEAK, m_start[i],
                                                          m_end[i] - m_start[i], 1'b0));
                pending_reports.push_back(make_report(ST_DONE, 32'd0, 32'd0, 1'b1));
            end
        endcase
    endfunction

    // result checker
    always @(posedge clk)
    begin
        report_t got;
        report_t want;
        if (rst_n && strobe)
        begin
            got = '{status, report_addr, report_len, heap_low, heap_high, last};
            results_seen++;
            if (status == ST_DONE) scans_seen++;
            if (status == ST_LEAK) leaks_seen++;
            if (pending_reports.size() == 0)
            begin
                errors++;
                if (mismatches++ < 10)
                    $display("unexpected result: %h", got);
            end
            else
            begin
                want = pending_reports.pop_front();
                if (got !== want)
                begin
                    errors++;
                    if (mismatches++ < 10)
                        $display("mismatch: want st=%0d ra=%h rl=%h lo=%h hi=%h l=%b, ",
                                 want.status, want.report_addr, want.report_len,
                                 want.heap_low, want.heap_high, want.last,
                                 "got st=%0d ra=%h rl=%h lo=%h hi=%h l=%b",
                                 got.status, got.report_addr, got.report_len,
                                 got.heap_low, got.heap_high, got.last);
                end
            end
        end
    end

    // one transfer; start stays high across back-to-back items
    task automatic send_event(logic [1:0] act, logic [31:0] a, logic [31:0] s,
                              logic [31:0] p);
        while (sender_idle > 0 && $urandom_range(99) < sender_idle)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        action <= act;
        block_addr <= a;
        block_size <= s;
        prior_addr <= p;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_event(act, a, s, p);
        @(negedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_reports.size() != 0)
            @(negedge clk);
        repeat (30) @(negedge clk);
    endtask

    task automatic set_redzone(logic [7:0] v);
        drain();
        redzone_we <= 1'b1;
        redzone_data <= v;
        @(negedge clk);
        redzone_we <= 1'b0;
        m_redzone = {24'd0, v};
    endtask

    function automatic logic [31:0] pick_addr();
        int r;
        r = $urandom_range(9);
        if (r < 5 && m_live > 0) return m_start[$urandom_range(m_live - 1)];
        if (r < 7 && m_freed_cnt > 0) return m_freed[$urandom_range(m_freed_cnt - 1)];
        if (r == 7) return $urandom;
        return {20'h10, 8'($urandom_range(255)), 4'h0};
    endfunction

    function automatic logic [31:0] pick_size();
        case ($urandom_range(7))
            0: return 32'd0;
            1: return $urandom;
            2: return 32'hffffffff;
            default: return $urandom_range(300);
        endcase
    endfunction

    vec_t directed [$];

    task automatic add_row(logic [1:0] act, logic [31:0] a, logic [31:0] s,
                           logic [31:0] p, bit typed, report_t want);
        vec_t v;
        v.action = act;
        v.addr = a;
        v.size = s;
        v.prior = p;
        v.typed = typed;
        v.want = want;
        directed.push_back(v);
    endtask

    initial begin
        report_t none;
        logic [1:0] act;
        none = '0;
        errors = 0;
        mismatches = 0;
        results_seen = 0;
        scans_seen = 0;
        leaks_seen = 0;
        sender_idle = 0;
        rst_n = 1'b0;
        start = 1'b0;
        action = ACT_ALLOC;
        block_addr = 0;
        block_size = 0;
        prior_addr = 0;
        redzone_we = 1'b0;
        redzone_data = 8'd0;
        track_reset();
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // scan on empty table, bad frees, then the usual life cycle
        add_row(ACT_SCAN, 0, 0, 0, 1, '{ST_DONE, 0, 0, 32'hffffffff, 0, 1'b1});
        add_row(ACT_FREE, 32'h1234, 0, 0, 1, '{ST_INVALID, 32'h1234, 0, 32'hffffffff, 0, 1'b1});
        add_row(ACT_REALLOC, 32'h2000, 32'd0, 32'h5000, 0, none);
        add_row(ACT_ALLOC, 32'h1000, 32'd0, 0, 0, none);
        add_row(ACT_ALLOC, 32'hffffffff, 32'hffffffff, 0, 0, none);
        add_row(ACT_ALLOC, 32'h0, 32'd100, 0, 0, none);
        add_row(ACT_FREE, 32'h1000, 0, 0, 0, none);
        add_row(ACT_FREE, 32'h1000, 0, 0, 0, none);
        add_row(ACT_REALLOC, 32'h3000, 32'd64, 32'h0, 0, none);
        add_row(ACT_REALLOC, 32'h4000, 32'd32, 32'h3000, 0, none);
        add_row(ACT_REALLOC, 32'h4800, 32'd32, 32'h3000, 0, none);
        add_row(ACT_REALLOC, 32'h0, 32'd0, 32'h4000, 0, none);
        add_row(ACT_REALLOC, 32'h0, 32'd0, 32'h4000, 0, none);
        add_row(ACT_SCAN, 0, 0, 0, 0, none);
        for (int i = 0; i < 18; i++)
            add_row(ACT_ALLOC, 32'h8000 + 32'h40 * i, 32'd8, 0, 0, none);
        add_row(ACT_SCAN, 0, 0, 0, 0, none);
        foreach (directed[i])
        begin
            if (directed[i].typed)
                pending_reports.push_back(directed[i].want);
            else
                predict_event(directed[i].action, directed[i].addr,
                              directed[i].size, directed[i].prior);
            start <= 1'b1;
            action <= directed[i].action;
            block_addr <= directed[i].addr;
            block_size <= directed[i].size;
            prior_addr <= directed[i].prior;
            @(posedge clk);
            while (busy)
                @(posedge clk);
            @(negedge clk);
            drain();
        end

        // random phases over several redzone settings
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: set_redzone(8'd0);
                1: set_redzone(8'd255);
                2: set_redzone(8'($urandom));
                3: set_redzone(8'd16);
                default: set_redzone(8'($urandom));
            endcase
            sender_idle = (ph < 2) ? 34 : (ph < 4 ? 78 : 0);
            for (int n = 0; n < RANDOM_EVENTS / 5; n++)
            begin
                act = 2'($urandom_range(3));
                if ($urandom_range(9) == 0) act = ACT_SCAN;
                if (act == ACT_SCAN && $urandom_range(2) != 0) act = ACT_ALLOC;
                if (n == 40) drain();
                send_event(act, act == ACT_ALLOC ? {20'h10, 8'($urandom_range(255)), 4'h0}
                                                 : pick_addr(),
                           pick_size(), $urandom_range(4) == 0 ? 32'd0 : pick_addr());
            end
        end
        drain();
        repeat (40) @(negedge clk);
        if (pending_reports.size() != 0) errors++;

        $display("covered %0d results: %0d scans, %0d leak reports, five redzone settings",
                 results_seen, scans_seen, leaks_seen);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
